>>> src/poc_pkg.sv
// ----------------------------------------------------------------------------
// poc_pkg
// Shared types and constants of the passivity observer and controller.
// ----------------------------------------------------------------------------
package poc_pkg;

    localparam int unsigned JOINTS_DEFAULT = 7;
    localparam int unsigned JOINTS_MAX     = 16;

    localparam logic [46:0] ENERGY_MAX = {47{1'b1}};
    localparam logic [30:0] GAIN_MAX   = {31{1'b1}};

    localparam logic [23:0] PERIOD_RESET = 24'd16777;
    localparam logic [31:0] FLOOR_RESET  = 32'd1;

    // configuration register indexes
    localparam logic [1:0] REG_SIDE_ROLE     = 2'd0;
    localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd1;
    localparam logic [1:0] REG_NORM_FLOOR    = 2'd2;

    // opcodes
    localparam logic OP_OBSERVE = 1'b0;
    localparam logic OP_CONTROL = 1'b1;

    // result kinds
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic signed [15:0] joint_velocity;
        logic signed [15:0] joint_force;
        logic               last_joint;
        logic signed [47:0] partner_energy;
    } in_item_t;

    typedef struct packed {
        logic               result_kind;
        logic signed [15:0] adjusted_sample;
        logic        [46:0] energy_in;
        logic        [46:0] energy_out;
        logic        [37:0] power_in;
        logic        [37:0] power_out;
        logic signed [31:0] damping_gain;
        logic               last_result;
    } out_item_t;

    // classified work between the front and the back
    typedef struct packed {
        logic               control;
        logic        [4:0]  count;
        logic signed [47:0] partner_energy;
    } job_t;

endpackage

>>> src/passivity_observer_controller_top.sv
// ----------------------------------------------------------------------------
// passivity_observer_controller_top
// Passivity observer and controller, one side of a two-port link.
// ----------------------------------------------------------------------------
// Control items enter one per cycle while a vector is open and the queue
// has room; an observe item that does not close its vector blocks further
// items until its power product is added. A last item closes the vector and
// is handed to the back end through a two-entry job queue. An observe vector
// passes through the back end's multiply, add and report steps. A control
// vector holds the joint buffer while the back end walks it: a pass over the
// joints for the norm, the gain divider (one quotient bit a cycle) when
// damping is active, then a multiply and an output step per emitted joint
// sample. New items are refused while a control vector owns the buffer.
module passivity_observer_controller_top
    import poc_pkg::*;
#(
    parameter int unsigned JOINTS = JOINTS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  in_item_t    data_in,
    output logic        empty,
    input  logic        pop,
    output out_item_t   data_out,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int unsigned IW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    logic               side_role_reg;
    logic [23:0]        period_reg;
    logic [31:0]        floor_reg;
    logic               job_valid;
    job_t               job;
    logic signed [39:0] job_power;
    logic               job_take;
    logic [IW-1:0]      rd_index;
    logic signed [15:0] rd_velocity;
    logic signed [15:0] rd_force;
    logic               buf_release;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_role_reg <= 1'b0;
            period_reg    <= PERIOD_RESET;
            floor_reg     <= FLOOR_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SIDE_ROLE:     side_role_reg <= cfg_data[0];
                REG_SAMPLE_PERIOD: period_reg    <= cfg_data[23:0];
                REG_NORM_FLOOR:    floor_reg     <= cfg_data;
                default:           ;
            endcase
        end
    end

    poc_front #(.JOINTS(JOINTS)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .data_in     (data_in),
        .job_valid   (job_valid),
        .job         (job),
        .job_power   (job_power),
        .job_take    (job_take),
        .rd_index    (rd_index),
        .rd_velocity (rd_velocity),
        .rd_force    (rd_force),
        .buf_release (buf_release)
    );

    poc_back #(.JOINTS(JOINTS)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .side_role     (side_role_reg),
        .sample_period (period_reg),
        .norm_floor    (floor_reg),
        .job_valid     (job_valid),
        .job           (job),
        .job_power     (job_power),
        .job_take      (job_take),
        .rd_index      (rd_index),
        .rd_velocity   (rd_velocity),
        .rd_force      (rd_force),
        .buf_release   (buf_release),
        .empty         (empty),
        .pop           (pop),
        .data_out      (data_out)
    );

endmodule

>>> src/poc_front.sv
// ----------------------------------------------------------------------------
// poc_front
// Accepts items, buffers joint vectors, accumulates power and hands closed
// vectors to the back end through a two-entry job queue.
// ----------------------------------------------------------------------------
module poc_front
    import poc_pkg::*;
#(
    parameter int unsigned JOINTS = JOINTS_DEFAULT,
    localparam int unsigned IW = (JOINTS > 1) ? $clog2(JOINTS) : 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  in_item_t           data_in,
    // job queue toward the back end
    output logic               job_valid,
    output job_t               job,
    output logic signed [39:0] job_power,
    input  logic               job_take,
    // buffer read port for the back end
    input  logic [IW-1:0]      rd_index,
    output logic signed [15:0] rd_velocity,
    output logic signed [15:0] rd_force,
    // buffer is free again
    input  logic               buf_release
);

    logic signed [15:0] vel_mem [JOINTS];
    logic signed [15:0] frc_mem [JOINTS];
    logic [4:0]         count_reg;
    logic signed [39:0] power_reg;
    logic signed [31:0] prod_reg;
    logic               prod_valid_reg;
    logic               busy_reg;          // closed control vector owns the buffer
    job_t               q_job_reg   [2];
    logic signed [39:0] q_power_reg [2];
    logic [1:0]         q_cnt_reg;
    logic               q_wr_reg;
    logic               q_rd_reg;
    logic               accept;
    logic               close;
    logic               in_range;

    // product register sits between items; the item after an observe item
    // that does not close its vector waits until its product is added
    assign full     = busy_reg || prod_valid_reg || (q_cnt_reg == 2'd2);
    assign accept   = push && !full;
    assign in_range = (count_reg < 5'(JOINTS));
    assign close    = accept && data_in.last_joint;

    // joint buffers
    always_ff @(posedge clk)
    begin
        if (accept && in_range)
        begin
            vel_mem[count_reg[IW-1:0]] <= data_in.joint_velocity;
            frc_mem[count_reg[IW-1:0]] <= data_in.joint_force;
        end
    end

    assign rd_velocity = vel_mem[rd_index];
    assign rd_force    = frc_mem[rd_index];

    // count, power accumulate and job queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            power_reg      <= '0;
            prod_valid_reg <= 1'b0;
            busy_reg       <= 1'b0;
            q_cnt_reg      <= '0;
            q_wr_reg       <= 1'b0;
            q_rd_reg       <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= 1'b0;
            if (prod_valid_reg)
                power_reg <= power_reg + 40'(prod_reg);
            if (accept)
            begin
                prod_reg <= data_in.joint_velocity * data_in.joint_force;
                prod_valid_reg <= in_range && (data_in.opcode == OP_OBSERVE)
                                  && !data_in.last_joint;
            end
            if (accept && !data_in.last_joint && in_range)
                count_reg <= count_reg + 5'd1;
            if (close)
            begin
                q_job_reg[q_wr_reg].control        <= data_in.opcode;
                q_job_reg[q_wr_reg].count          <= in_range ? count_reg + 5'd1
                                                                : count_reg;
                q_job_reg[q_wr_reg].partner_energy <= data_in.partner_energy;
                q_power_reg[q_wr_reg] <= (in_range && data_in.opcode == OP_OBSERVE)
                    ? power_reg + 40'(data_in.joint_velocity) * 40'(data_in.joint_force)
                    : power_reg;
                q_wr_reg  <= ~q_wr_reg;
                count_reg <= '0;
                power_reg <= '0;
                busy_reg  <= (data_in.opcode == OP_CONTROL);
            end
            if (buf_release)
                busy_reg <= 1'b0;
            if (job_take)
                q_rd_reg <= ~q_rd_reg;
            q_cnt_reg <= q_cnt_reg + {1'b0, close} - {1'b0, job_take};
        end
    end

    assign job_valid = (q_cnt_reg != 2'd0);
    assign job       = q_job_reg[q_rd_reg];
    assign job_power = q_power_reg[q_rd_reg];

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg <= 2'd2) else $error("job queue overflow");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !accept) else $error("item accepted while buffer held");
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |-> job_valid) else $error("job taken from empty queue");

endmodule

>>> src/poc_divider.sv
// ----------------------------------------------------------------------------
// poc_divider
// Restoring divider giving floor(num * 2^36 / den), saturated to 31 bits.
// ----------------------------------------------------------------------------
module poc_divider
    import poc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] num,
    input  logic [63:0] den,
    output logic        done,
    output logic [30:0] quot
);

    localparam int unsigned STEPS = 84;    // 48 integer bits plus 36 fraction

    logic [83:0] dividend_reg;
    logic [63:0] den_reg;
    logic [64:0] rem_reg;
    logic [31:0] q_reg;
    logic        sat_reg;
    logic [6:0]  step_reg;
    logic        run_reg;
    logic [64:0] rem_shift;
    logic        ge;

    assign rem_shift = {rem_reg[63:0], dividend_reg[83]};
    assign ge        = (rem_shift >= {1'b0, den_reg});

    // one quotient bit a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done     <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                run_reg      <= 1'b1;
                step_reg     <= '0;
                dividend_reg <= {num, 36'd0};
                den_reg      <= den;
                rem_reg      <= '0;
                q_reg        <= '0;
                sat_reg      <= (den == '0);
            end
            else if (run_reg)
            begin
                dividend_reg <= {dividend_reg[82:0], 1'b0};
                rem_reg      <= ge ? rem_shift - {1'b0, den_reg} : rem_shift;
                q_reg        <= {q_reg[30:0], ge};
                if (q_reg[31:30] != 2'b00)
                    sat_reg <= 1'b1;
                step_reg <= step_reg + 7'd1;
                if (step_reg == 7'(STEPS - 1))
                begin
                    run_reg <= 1'b0;
                    done    <= 1'b1;
                end
            end
        end
    end

    assign quot = (sat_reg || q_reg[31]) ? GAIN_MAX : q_reg[30:0];

endmodule

>>> src/poc_back.sv
// ----------------------------------------------------------------------------
// poc_back
// Executes jobs: energy integration for observe vectors, norm, gain and
// the joint sample walk for control vectors, into a two-entry result queue.
// ----------------------------------------------------------------------------
module poc_back
    import poc_pkg::*;
#(
    parameter int unsigned JOINTS = JOINTS_DEFAULT,
    localparam int unsigned IW = (JOINTS > 1) ? $clog2(JOINTS) : 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               side_role,
    input  logic [23:0]        sample_period,
    input  logic [31:0]        norm_floor,
    input  logic               job_valid,
    input  job_t               job,
    input  logic signed [39:0] job_power,
    output logic               job_take,
    output logic [IW-1:0]      rd_index,
    input  logic signed [15:0] rd_velocity,
    input  logic signed [15:0] rd_force,
    output logic               buf_release,
    output logic               empty,
    input  logic               pop,
    output out_item_t          data_out
);

    typedef enum logic [3:0] {
        S_IDLE, S_OBS_MUL, S_OBS_ADD, S_NORM, S_EPC, S_AMUL, S_DIV,
        S_DIS_LO, S_DIS_ADD, S_WALK_MUL, S_WALK_OUT, S_REPORT
    } state_t;

    state_t             state_reg;
    logic [46:0]        ein_reg;
    logic [46:0]        eout_reg;
    logic [46:0]        edis_reg;
    logic [37:0]        pin_reg;
    logic [37:0]        pout_reg;
    logic [30:0]        gain_reg;
    logic [39:0]        norm_reg;
    logic [4:0]         idx_reg;
    job_t               job_reg;
    logic [63:0]        prod_a_reg;     // period * power, period * norm
    logic [63:0]        prod_b_reg;
    logic signed [49:0] epc_reg;
    logic [63:0]        hi_reg;
    logic [63:0]        lo_reg;
    logic signed [47:0] adj_reg;
    logic signed [15:0] samp_reg;
    logic               div_start;
    logic               div_done;
    logic [30:0]        div_quot;
    out_item_t          q_reg [2];
    logic [1:0]         q_cnt_reg;
    logic               q_wr_reg;
    logic               q_rd_reg;
    logic               q_push;
    out_item_t          q_item;
    logic signed [15:0] d_sel;
    logic signed [15:0] s_sel;
    logic [47:0]        dis_add;
    logic signed [17:0] sum;
    logic signed [15:0] sat_sample;

    assign rd_index = idx_reg[IW-1:0];
    assign d_sel    = side_role ? rd_force : rd_velocity;
    assign s_sel    = side_role ? rd_velocity : rd_force;

    poc_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (48'(-epc_reg)),
        .den   (prod_a_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign div_start = (state_reg == S_EPC) && (epc_reg < 0)
                       && (norm_reg > 40'(norm_floor));

    // dissipated increment from the split product
    assign dis_add = 48'(hi_reg >> 4) + 48'((({60'd0, hi_reg[3:0]} << 32)
                     + {4'd0, lo_reg}) >> 36);

    // sample add and saturate
    assign sum        = 18'(samp_reg) + 18'(adj_reg);
    assign sat_sample = (adj_reg > 48'sd65535)  ? 16'sh7FFF :
                        (adj_reg < -48'sd65536) ? 16'sh8000 :
                        (sum > 18'sd32767)      ? 16'sh7FFF :
                        (sum < -18'sd32768)     ? 16'sh8000 : sum[15:0];

    // result queue
    assign q_push = ((state_reg == S_WALK_OUT) || (state_reg == S_REPORT))
                    && (q_cnt_reg != 2'd2);
    always_comb
    begin
        q_item.result_kind     = (state_reg == S_WALK_OUT) ? KIND_SAMPLE : KIND_REPORT;
        q_item.adjusted_sample = (state_reg == S_WALK_OUT) ? sat_sample : '0;
        q_item.energy_in       = ein_reg;
        q_item.energy_out      = eout_reg;
        q_item.power_in        = pin_reg;
        q_item.power_out       = pout_reg;
        q_item.damping_gain    = {1'b0, gain_reg};
        q_item.last_result     = (state_reg == S_REPORT) || (idx_reg + 5'd1 == job_reg.count);
    end

    assign empty    = (q_cnt_reg == 2'd0);
    assign data_out = q_reg[q_rd_reg];

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ein_reg     <= '0;
            eout_reg    <= '0;
            edis_reg    <= '0;
            pin_reg     <= '0;
            pout_reg    <= '0;
            gain_reg    <= '0;
            idx_reg     <= '0;
            job_take    <= 1'b0;
            buf_release <= 1'b0;
            q_cnt_reg   <= '0;
            q_wr_reg    <= 1'b0;
            q_rd_reg    <= 1'b0;
        end
        else
        begin
            job_take    <= 1'b0;
            buf_release <= 1'b0;
            if (q_push)
            begin
                q_reg[q_wr_reg] <= q_item;
                q_wr_reg <= ~q_wr_reg;
            end
            if (pop && !empty)
                q_rd_reg <= ~q_rd_reg;
            q_cnt_reg <= q_cnt_reg + {1'b0, q_push} - {1'b0, pop && !empty};
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid && !job_take)
                    begin
                        job_reg  <= job;
                        job_take <= 1'b1;
                        idx_reg  <= '0;
                        norm_reg <= '0;
                        if (job.control)
                            state_reg <= S_NORM;
                        else
                        begin
                            pin_reg   <= (job_power > 0) ? 38'(job_power) : '0;
                            pout_reg  <= (job_power > 0) ? '0 : 38'(-job_power);
                            state_reg <= S_OBS_MUL;
                        end
                    end
                end
                S_OBS_MUL:
                begin
                    prod_a_reg <= 64'(pin_reg) * 64'(sample_period);
                    prod_b_reg <= 64'(pout_reg) * 64'(sample_period);
                    state_reg  <= S_OBS_ADD;
                end
                S_OBS_ADD:
                begin
                    ein_reg <= (48'(ein_reg) + 48'(prod_a_reg >> 20) > 48'(ENERGY_MAX))
                               ? ENERGY_MAX : 47'(48'(ein_reg) + 48'(prod_a_reg >> 20));
                    eout_reg <= (48'(eout_reg) + 48'(prod_b_reg >> 20) > 48'(ENERGY_MAX))
                               ? ENERGY_MAX : 47'(48'(eout_reg) + 48'(prod_b_reg >> 20));
                    state_reg <= S_REPORT;
                end
                S_REPORT:
                begin
                    if (q_push)
                        state_reg <= S_IDLE;
                end
                S_NORM:
                begin
                    if (idx_reg == job_reg.count)
                    begin
                        idx_reg   <= '0;
                        epc_reg   <= 50'(job_reg.partner_energy) - 50'(eout_reg)
                                     + 50'(edis_reg);
                        state_reg <= S_AMUL;
                    end
                    else
                    begin
                        norm_reg <= norm_reg + 40'(32'(d_sel) * 32'(d_sel));
                        idx_reg  <= idx_reg + 5'd1;
                    end
                end
                S_AMUL:
                begin
                    prod_a_reg <= 64'(norm_reg) * 64'(sample_period);
                    state_reg  <= S_EPC;
                end
                S_EPC:
                begin
                    if (div_start)
                        state_reg <= S_DIV;
                    else
                    begin
                        gain_reg  <= '0;
                        state_reg <= S_WALK_MUL;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        gain_reg  <= div_quot;
                        hi_reg    <= 64'(prod_a_reg[63:32]) * 64'(div_quot);
                        state_reg <= S_DIS_LO;
                    end
                end
                S_DIS_LO:
                begin
                    lo_reg    <= 64'(prod_a_reg[31:0]) * 64'(gain_reg);
                    state_reg <= S_DIS_ADD;
                end
                S_DIS_ADD:
                begin
                    edis_reg <= (48'(edis_reg) + 48'(dis_add > 48'(ENERGY_MAX)
                                 ? 48'(ENERGY_MAX) : dis_add) > 48'(ENERGY_MAX))
                                ? ENERGY_MAX
                                : 47'(48'(edis_reg) + (dis_add > 48'(ENERGY_MAX)
                                 ? 48'(ENERGY_MAX) : dis_add));
                    state_reg <= S_WALK_MUL;
                end
                S_WALK_MUL:
                begin
                    if (idx_reg == job_reg.count)
                    begin
                        buf_release <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                    else
                    begin
                        adj_reg   <= (48'($signed({1'b0, gain_reg})) * 48'(d_sel)) >>> 16;
                        samp_reg  <= s_sel;
                        state_reg <= S_WALK_OUT;
                    end
                end
                S_WALK_OUT:
                begin
                    if (q_push)
                    begin
                        idx_reg   <= idx_reg + 5'd1;
                        state_reg <= S_WALK_MUL;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg <= 2'd2) else $error("result queue overflow");
    a_gain_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EPC && !div_start) |=> gain_reg == '0)
        else $error("gain not cleared without damping");
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV) else $error("stray divider done");

endmodule
